/* hdl/slcan_pkg.sv */
`default_nettype none

package slcan_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_MALFORMED   = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } status_t;

    // Frame kind selected by the first character of a line.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_STD   = 2'd1,
        KIND_EXT   = 2'd2,
        KIND_UNSUP = 2'd3
    } kind_t;

    // Progress through the optional line terminator.
    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_CR   = 2'd1,
        TAIL_LF   = 2'd2
    } tail_t;

    // Character codes.
    localparam logic [7:0] CHR_STD_FRAME = "t";
    localparam logic [7:0] CHR_EXT_FRAME = "T";
    localparam logic [7:0] CHR_CR        = 8'h0D;
    localparam logic [7:0] CHR_LF        = 8'h0A;
    localparam logic [7:0] CHR_RTR_STD   = "r";
    localparam logic [7:0] CHR_RTR_EXT   = "R";
    localparam logic [7:0] CHR_FD_STD    = "d";
    localparam logic [7:0] CHR_FD_EXT    = "D";
    localparam logic [7:0] CHR_BRS_STD   = "b";
    localparam logic [7:0] CHR_BRS_EXT   = "B";

    // Identifier digit counts and limits.
    localparam logic [3:0]  STD_ID_DIGITS = 4'd3;
    localparam logic [3:0]  EXT_ID_DIGITS = 4'd8;
    localparam logic [31:0] STD_ID_MAX    = 32'h0000_07FF;
    localparam logic [31:0] EXT_ID_MAX    = 32'h1FFF_FFFF;
    localparam logic [3:0]  DLC_MAX       = 4'd8;

    // Output data width, padded to whole bytes.
    localparam int RESULT_BITS = 2 + 29 + 1 + 4 + 64;
    localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

    // One input character with its end-of-line mark.
    typedef struct packed {
        logic [7:0] character;
        logic       line_done;
    } item_t;

    // One parsed frame result.
    typedef struct packed {
        status_t     status;
        logic [28:0] frame_id;
        logic        extended;
        logic [3:0]  dlc;
        logic [63:0] payload;
    } result_t;

endpackage

`default_nettype wire

/* hdl/slcan_frame_parser.sv */
// Stages: input register, parser logic, result register; an end-of-line item loads the result.
// Throughput: one character per cycle, except while an end-of-line item waits for result space.
// Characters that do not end a line never wait on the output side.
// Reset: asynchronous active-low; clears both stage valids and all parser state,
// leaving the parser at line start.
`default_nettype none

module slcan_frame_parser (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // character[7:0]
    input  wire logic                              s_tlast,   // line_done
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status[1:0], frame_id[30:2], extended[31], dlc[35:32], payload[99:36], zero pad
    output logic [slcan_pkg::TDATA_BITS-1:0]       m_tdata
);
    import slcan_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    advance;
    logic    emit;
    logic    space;
    result_t result;

    // An item moves on unless it ends a line and the result register is full.
    assign advance = item_valid && (!item.line_done || space);

    slcan_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    slcan_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .emit   (emit),
        .result (result)
    );

    slcan_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (emit),
        .result   (result),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* hdl/slcan_in_stage.sv */
`default_nettype none

module slcan_in_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // character[7:0]
    input  wire logic                 s_tlast,   // line_done
    input  wire logic                 advance,
    output logic                      item_valid,
    output slcan_pkg::item_t          item
);
    import slcan_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // The register can take a new transaction when empty or when its item moves on.
    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.character <= s_tdata;
            item_reg.line_done <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* hdl/slcan_parse.sv */
`default_nettype none

module slcan_parse (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire slcan_pkg::item_t     item,
    output logic                      emit,
    output slcan_pkg::result_t        result
);
    import slcan_pkg::*;

    logic [4:0]  position_reg,   position_next;
    kind_t       kind_reg,       kind_next;
    logic [31:0] id_reg,         id_next;
    logic [3:0]  length_reg,     length_next;
    logic [63:0] data_reg,       data_next;
    logic [3:0]  upper_reg,      upper_next;
    logic        failed_reg,     failed_next;
    tail_t       tail_reg,       tail_next;

    logic [3:0]  id_digits;
    logic [4:0]  data_end;
    logic [4:0]  dlc_pos;
    logic [4:0]  q;
    logic [4:0]  hex;
    logic [7:0]  data_byte;
    logic [63:0] byte_shifted;
    logic [7:0]  c;
    status_t     status;

    // Hex digit decode: bit 4 flags a valid digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= "0" && ch <= "9")
        begin
            r = {1'b1, 4'(ch - "0")};
        end
        else if (ch >= "A" && ch <= "F")
        begin
            r = {1'b1, 4'(ch - "A" + 8'd10)};
        end
        else if (ch >= "a" && ch <= "f")
        begin
            r = {1'b1, 4'(ch - "a" + 8'd10)};
        end
        return r;
    endfunction

    // Field positions within the line.
    assign c         = item.character;
    assign id_digits = (kind_reg == KIND_EXT) ? EXT_ID_DIGITS : STD_ID_DIGITS;
    assign dlc_pos   = {1'b0, id_digits} + 5'd1;
    assign data_end  = {1'b0, id_digits} + 5'd2 + {length_reg, 1'b0};
    assign q         = position_reg - ({1'b0, id_digits} + 5'd2);
    assign hex       = hex_decode(c);
    assign data_byte = {upper_reg, hex[3:0]};
    assign byte_shifted = {56'd0, data_byte} << {q[3:1], 3'b000};

    // Next state for one character, or return to line start at end of line.
    always_comb
    begin
        position_next = position_reg;
        kind_next     = kind_reg;
        id_next       = id_reg;
        length_next   = length_reg;
        data_next     = data_reg;
        upper_next    = upper_reg;
        failed_next   = failed_reg;
        tail_next     = tail_reg;

        if (fire && item.line_done)
        begin
            position_next = 5'd0;
            kind_next     = KIND_NONE;
            id_next       = 32'd0;
            length_next   = 4'd0;
            data_next     = 64'd0;
            upper_next    = 4'd0;
            failed_next   = 1'b0;
            tail_next     = TAIL_NONE;
        end
        else if (fire && !failed_reg && kind_reg != KIND_UNSUP)
        begin
            if (position_reg == 5'd0)
            begin
                if (c == CHR_RTR_STD || c == CHR_RTR_EXT || c == CHR_FD_STD ||
                    c == CHR_FD_EXT || c == CHR_BRS_STD || c == CHR_BRS_EXT)
                begin
                    kind_next = KIND_UNSUP;
                end
                else if (c == CHR_STD_FRAME)
                begin
                    kind_next = KIND_STD;
                end
                else if (c == CHR_EXT_FRAME)
                begin
                    kind_next = KIND_EXT;
                end
                else
                begin
                    failed_next = 1'b1;
                end
                position_next = 5'd1;
            end
            else if (position_reg >= data_end)
            begin
                // Terminator: CR, CR LF or LF, nothing after.
                if (tail_reg == TAIL_NONE && c == CHR_CR)
                begin
                    tail_next = TAIL_CR;
                end
                else if (tail_reg != TAIL_LF && c == CHR_LF)
                begin
                    tail_next = TAIL_LF;
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
            else if (!hex[4])
            begin
                failed_next = 1'b1;
            end
            else if (position_reg <= {1'b0, id_digits})
            begin
                id_next       = {id_reg[27:0], hex[3:0]};
                position_next = position_reg + 5'd1;
            end
            else if (position_reg == dlc_pos)
            begin
                if (hex[3:0] > DLC_MAX)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    length_next   = hex[3:0];
                    position_next = position_reg + 5'd1;
                end
            end
            else
            begin
                // Even offset holds the high nibble, odd offset completes a byte.
                if (!q[0])
                begin
                    upper_next = hex[3:0];
                end
                else
                begin
                    data_next = data_reg | byte_shifted;
                end
                position_next = position_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= 5'd0;
            kind_reg     <= KIND_NONE;
            id_reg       <= 32'd0;
            length_reg   <= 4'd0;
            data_reg     <= 64'd0;
            upper_reg    <= 4'd0;
            failed_reg   <= 1'b0;
            tail_reg     <= TAIL_NONE;
        end
        else
        begin
            position_reg <= position_next;
            kind_reg     <= kind_next;
            id_reg       <= id_next;
            length_reg   <= length_next;
            data_reg     <= data_next;
            upper_reg    <= upper_next;
            failed_reg   <= failed_next;
            tail_reg     <= tail_next;
        end
    end

    // Final verdict for the line.
    always_comb
    begin
        if (kind_reg == KIND_UNSUP)
        begin
            status = ST_UNSUPPORTED;
        end
        else if (failed_reg || position_reg == 5'd0 || position_reg < data_end)
        begin
            status = ST_MALFORMED;
        end
        else if (kind_reg == KIND_STD && id_reg > STD_ID_MAX)
        begin
            status = ST_MALFORMED;
        end
        else if (kind_reg == KIND_EXT && id_reg > EXT_ID_MAX)
        begin
            status = ST_MALFORMED;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // Result fields are zero unless the frame parsed cleanly.
    always_comb
    begin
        result.status   = status;
        result.frame_id = 29'd0;
        result.extended = 1'b0;
        result.dlc      = 4'd0;
        result.payload  = 64'd0;
        if (status == ST_OK)
        begin
            result.frame_id = id_reg[28:0];
            result.extended = (kind_reg == KIND_EXT);
            result.dlc      = length_reg;
            result.payload  = data_reg;
        end
    end

    assign emit = fire && item.line_done;

`ifndef SYNTHESIS
    // The parser is back at line start after every end of line.
    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (position_reg == 5'd0 && kind_reg == KIND_NONE && !failed_reg))
        else $error("parser did not return to line start");

    // Position never runs past the longest extended frame.
    a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= 5'd26)
        else $error("parser position out of range");

    // A clean frame never carries a length above eight.
    a_dlc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (status == ST_OK) |-> (length_reg <= DLC_MAX))
        else $error("accepted frame with DLC above eight");
`endif

endmodule

`default_nettype wire

/* hdl/slcan_out_stage.sv */
`default_nettype none

module slcan_out_stage (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire slcan_pkg::result_t                result,
    output logic                                   space,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status[1:0], frame_id[30:2], extended[31], dlc[35:32], payload[99:36], zero pad
    output logic [slcan_pkg::TDATA_BITS-1:0]       m_tdata
);
    import slcan_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    logic [TDATA_BITS-1:0]   data_reg;

    // The register frees up as soon as its transaction completes.
    assign space = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Pack fields from the lowest bit up.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {{(TDATA_BITS - RESULT_BITS){1'b0}}, result.payload, result.dlc,
                         result.extended, result.frame_id, result.status};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

`ifndef SYNTHESIS
    // A result is only loaded when the register has room for it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> space)
        else $error("result register overwritten before its transaction");
`endif

endmodule

`default_nettype wire
